// File: rtl/lrubc_pkg.sv
package lrubc_pkg;

  localparam int BUFFER_COUNT = 16;
  localparam int IDX_W = $clog2(BUFFER_COUNT);

  localparam int SLOT_W = 4;
  localparam int DEV_W = 8;
  localparam int BLK_W = 32;
  localparam int REF_W = 8;
  localparam logic [REF_W-1:0] REF_MAX = '1;

  typedef enum logic [1:0] {
    CMD_READ    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DONE    = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFREE  = 2'd1,
    ST_NOTHELD = 2'd2
  } status_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_PICK,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic pick;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/lrubc_ctrl.sv
module lrubc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lrubc_pkg::dp_stat_t stat,
  output lrubc_pkg::dp_cmd_t  cmd
);

  lrubc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrubc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      lrubc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = lrubc_pkg::S_COMPARE;
        end
      end
      lrubc_pkg::S_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = lrubc_pkg::S_PICK;
      end
      lrubc_pkg::S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = lrubc_pkg::S_UPDATE;
      end
      lrubc_pkg::S_UPDATE: begin
        // The state change is committed together with the result word.
        if (stat.out_free) begin
          cmd.update = 1'b1;
          state_next = lrubc_pkg::S_IDLE;
        end
      end
      default: state_next = lrubc_pkg::S_IDLE;
    endcase
  end

endmodule

// File: rtl/lrubc_dp.sv
module lrubc_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  lrubc_pkg::dp_cmd_t             cmd,
  output lrubc_pkg::dp_stat_t            stat,
  input  logic [1:0]                     command,
  input  logic [lrubc_pkg::DEV_W-1:0]    device,
  input  logic [lrubc_pkg::BLK_W-1:0]    block_number,
  input  logic [lrubc_pkg::SLOT_W-1:0]   buffer_slot,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lrubc_pkg::SLOT_W-1:0]   slot_out,
  output logic                           was_hit,
  output logic                           need_disk_read,
  output logic                           need_disk_write,
  output logic [1:0]                     status
);

  localparam int N = lrubc_pkg::BUFFER_COUNT;
  localparam int IW = lrubc_pkg::IDX_W;

  // Captured request.
  logic [1:0]                   cmd_q;
  logic [lrubc_pkg::DEV_W-1:0]  dev_q;
  logic [lrubc_pkg::BLK_W-1:0]  blk_q;
  logic [lrubc_pkg::SLOT_W-1:0] slot_q;

  // Buffer state.
  logic [lrubc_pkg::DEV_W-1:0] tag_device [N];
  logic [lrubc_pkg::BLK_W-1:0] tag_block  [N];
  logic [N-1:0]                tag_present;
  logic [lrubc_pkg::REF_W-1:0] ref_count  [N];
  logic [N-1:0]                valid_mark;
  logic [N-1:0]                dirty_mark;
  logic [IW-1:0]               rank       [N];

  // Search results.
  logic [N-1:0]  match_vec;
  logic [N-1:0]  free_vec;
  logic          hit;
  logic          found;
  logic [IW-1:0] chosen;

  logic [N-1:0]  match_by_rank;
  logic [N-1:0]  free_by_rank;
  logic [IW-1:0] hit_rank;
  logic [IW-1:0] free_rank;
  logic          any_match;
  logic          any_free;
  logic [IW-1:0] pick_rank;
  logic [IW-1:0] pick_slot;

  logic                        slot_in_range;
  logic [IW-1:0]               sidx;
  logic [IW-1:0]               ref_addr;
  logic [lrubc_pkg::REF_W-1:0] ref_rd;
  logic [IW-1:0]               rel_rank;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= command;
      dev_q  <= device;
      blk_q  <= block_number;
      slot_q <= buffer_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < N; i++) begin
        match_vec[i] <= tag_present[i] && (tag_device[i] == dev_q) &&
                        (tag_block[i] == blk_q);
        free_vec[i]  <= (ref_count[i] == '0) && !dirty_mark[i];
      end
    end
  end

  // Ranks are always a permutation, so the candidates can be laid out by rank
  // and the best one found with a priority encoder.
  always_comb begin
    match_by_rank = '0;
    free_by_rank  = '0;
    for (int r = 0; r < N; r++) begin
      for (int i = 0; i < N; i++) begin
        if (rank[i] == IW'(r)) begin
          match_by_rank[r] = match_vec[i];
          free_by_rank[r]  = free_vec[i];
        end
      end
    end
    hit_rank  = '0;
    free_rank = '0;
    any_match = |match_by_rank;
    any_free  = |free_by_rank;
    for (int r = 0; r < N; r++) begin
      if (match_by_rank[r]) begin
        hit_rank = IW'(r);
      end
    end
    for (int r = N - 1; r >= 0; r--) begin
      if (free_by_rank[r]) begin
        free_rank = IW'(r);
      end
    end
    pick_rank = any_match ? hit_rank : free_rank;
    pick_slot = '0;
    for (int i = 0; i < N; i++) begin
      if (rank[i] == pick_rank) begin
        pick_slot = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      hit    <= any_match;
      found  <= any_match || any_free;
      chosen <= pick_slot;
    end
  end

  assign slot_in_range = int'(slot_q) < N;
  assign sidx          = slot_q[IW-1:0];
  assign ref_addr      = (cmd_q == lrubc_pkg::CMD_READ) ? chosen : sidx;
  assign ref_rd        = ref_count[ref_addr];
  assign rel_rank      = rank[sidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_present <= '0;
      valid_mark  <= '0;
      dirty_mark  <= '0;
      for (int i = 0; i < N; i++) begin
        ref_count[i] <= '0;
        rank[i]      <= IW'(i);
      end
    end else if (cmd.update) begin
      if (cmd_q == lrubc_pkg::CMD_READ) begin
        if (hit) begin
          if (ref_rd != lrubc_pkg::REF_MAX) begin
            ref_count[chosen] <= ref_rd + 1'b1;
          end
        end else if (found) begin
          tag_device[chosen]  <= dev_q;
          tag_block[chosen]   <= blk_q;
          tag_present[chosen] <= 1'b1;
          valid_mark[chosen]  <= 1'b0;
          dirty_mark[chosen]  <= 1'b0;
          ref_count[chosen]   <= lrubc_pkg::REF_W'(1);
        end
      end else if (slot_in_range) begin
        if (cmd_q == lrubc_pkg::CMD_DONE) begin
          valid_mark[sidx] <= 1'b1;
          dirty_mark[sidx] <= 1'b0;
        end else if (ref_rd != '0) begin
          if (cmd_q == lrubc_pkg::CMD_WRITE) begin
            dirty_mark[sidx] <= 1'b1;
          end else begin
            ref_count[sidx] <= ref_rd - 1'b1;
            // Last holder gone: the buffer becomes the most recent one.
            if (ref_rd == lrubc_pkg::REF_W'(1)) begin
              for (int i = 0; i < N; i++) begin
                if (rank[i] > rel_rank) begin
                  rank[i] <= rank[i] - 1'b1;
                end
              end
              rank[sidx] <= IW'(N - 1);
            end
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.update) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      slot_out        <= slot_q;
      was_hit         <= 1'b0;
      need_disk_read  <= 1'b0;
      need_disk_write <= 1'b0;
      status          <= lrubc_pkg::ST_OK;
      if (cmd_q == lrubc_pkg::CMD_READ) begin
        slot_out <= lrubc_pkg::SLOT_W'(chosen);
        if (hit) begin
          was_hit        <= 1'b1;
          need_disk_read <= !valid_mark[chosen];
        end else if (found) begin
          need_disk_read <= 1'b1;
        end else begin
          slot_out <= '0;
          status   <= lrubc_pkg::ST_NOFREE;
        end
      end else if (!slot_in_range) begin
        status <= lrubc_pkg::ST_NOTHELD;
      end else if (cmd_q != lrubc_pkg::CMD_DONE) begin
        if (ref_rd == '0) begin
          status <= lrubc_pkg::ST_NOTHELD;
        end else if (cmd_q == lrubc_pkg::CMD_WRITE) begin
          need_disk_write <= 1'b1;
        end
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

// File: rtl/lru_block_buffer_cache_core.sv
// A request word passes through capture, tag compare, rank pick and state update;
// the result word is offered once the update step has written the result register.
// A new request is accepted only from idle, after the previous one has finished;
// a stalled result holds the update step, and the request in flight waits until
// the result register frees.
// Reset clears the counts, marks and result valid flag and restores rank order.
module lru_block_buffer_cache_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // command[1:0], device[9:2], block_number[41:10], buffer_slot[45:42], zero fill
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // slot_out[3:0], was_hit[4], need_disk_read[5], need_disk_write[6],
  // status[8:7], zero fill
  output logic [15:0] m_tdata
);

  lrubc_pkg::dp_cmd_t  cmd;
  lrubc_pkg::dp_stat_t stat;

  logic [lrubc_pkg::SLOT_W-1:0] slot_out;
  logic                         was_hit;
  logic                         need_disk_read;
  logic                         need_disk_write;
  logic [1:0]                   status;

  lrubc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrubc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .command         (s_tdata[1:0]),
    .device          (s_tdata[9:2]),
    .block_number    (s_tdata[41:10]),
    .buffer_slot     (s_tdata[45:42]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .slot_out        (slot_out),
    .was_hit         (was_hit),
    .need_disk_read  (need_disk_read),
    .need_disk_write (need_disk_write),
    .status          (status)
  );

  assign m_tdata = {7'd0, status, need_disk_write, need_disk_read, was_hit, slot_out};

endmodule
